// ===== rtl/mqb_pkg.sv =====
// Shared definitions for the multilevel queue bank: field widths, command and
// status codes, the sequencer state type and the control word of a slot cell.
// No dependencies; compile first.
package mqb_pkg;

  // Field widths of the request and response transfers
  localparam int CMD_W    = 1;
  localparam int SEL_W    = 16;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 2;
  localparam int RQ_W     = 3;
  localparam int QC_W     = 7;

  // Default geometry
  localparam int DEF_NUM_QUEUES  = 5;
  localparam int DEF_QUEUE_DEPTH = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP    = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXEC
  } mqb_state_t;

  // Per-cell control: load the inserted id, or take the neighbour's entry
  typedef struct packed {
    logic load;
    logic shift;
  } mqb_cell_ctrl_t;

endpackage

// ===== rtl/mqb_req_if.sv =====
// Request channel of the queue bank: valid/ready plus command, queue number
// and process id. Depends on mqb_pkg for the field widths.
interface mqb_req_if;
  logic                              valid;
  logic                              ready;
  logic [mqb_pkg::CMD_W-1:0]         cmd;
  logic signed [mqb_pkg::SEL_W-1:0]  queue_sel;
  logic [mqb_pkg::ID_W-1:0]          proc_id;

  modport source (output valid, output cmd, output queue_sel, output proc_id, input ready);
  modport sink   (input valid, input cmd, input queue_sel, input proc_id, output ready);
endinterface

// ===== rtl/mqb_rsp_if.sv =====
// Response channel of the queue bank: valid/ready plus status, popped id,
// resolved queue and resulting count. Depends on mqb_pkg for the field widths.
interface mqb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mqb_pkg::STATUS_W-1:0]   status;
  logic [mqb_pkg::ID_W-1:0]       popped_id;
  logic [mqb_pkg::RQ_W-1:0]       resolved_queue;
  logic [mqb_pkg::QC_W-1:0]       queue_count;

  modport source (output valid, output status, output popped_id,
                  output resolved_queue, output queue_count, input ready);
  modport sink   (input valid, input status, input popped_id,
                  input resolved_queue, input queue_count, output ready);
endinterface

// ===== rtl/mqb_reduce.sv =====
// Registered reduction of a signed 16-bit queue number to 0..NUM_QUEUES-1.
// Reciprocal multiply on start, correction and sign offset on finish.
// Depends on mqb_pkg.
module mqb_reduce #(
  parameter int NUM_QUEUES = mqb_pkg::DEF_NUM_QUEUES,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                             clk,
  input  logic                             start,
  input  logic                             finish,
  input  logic signed [mqb_pkg::SEL_W-1:0] sel,
  output logic [QW-1:0]                    qidx
);
  import mqb_pkg::*;

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SEL_W + RECIP_W;
  localparam int RW          = QW + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT) / NUM_QUEUES);
  // Offset of the sign bias: 32768 mod NUM_QUEUES
  localparam logic [RW-1:0] BIAS_MOD = RW'((2 ** (SEL_W - 1)) % NUM_QUEUES);
  localparam logic [RW-1:0] NQ       = RW'(NUM_QUEUES);

  logic [SEL_W-1:0]  biased;
  logic [PROD_W-1:0] prod;
  logic [SEL_W-1:0]  quot_est;
  logic [SEL_W-1:0]  sel_u;
  logic [SEL_W-1:0]  back;
  logic [SEL_W-1:0]  diff;
  logic [RW-1:0]     rem_raw;
  logic [RW-1:0]     rem_u;
  logic [RW-1:0]     rem_s;

  // Bias to unsigned: value + 32768
  assign biased = {~sel[SEL_W-1], sel[SEL_W-2:0]};
  assign prod   = PROD_W'(biased) * PROD_W'(RECIP);

  // Quotient estimate is exact or one short
  always_ff @(posedge clk) begin
    if (start) begin
      sel_u    <= biased;
      quot_est <= prod[RECIP_SHIFT +: SEL_W];
    end
  end

  // Remainder below twice the queue count: one correction
  always_comb begin
    back    = SEL_W'(quot_est * SEL_W'(NUM_QUEUES));
    diff    = sel_u - back;
    rem_raw = diff[RW-1:0];
    rem_u   = (rem_raw >= NQ) ? rem_raw - NQ : rem_raw;
    rem_s   = (rem_u >= BIAS_MOD) ? rem_u - BIAS_MOD : rem_u + NQ - BIAS_MOD;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      qidx <= rem_s[QW-1:0];
    end
  end

endmodule

// ===== rtl/mqb_cell.sv =====
// One slot position of the queue bank, holding that position for every queue.
// Loads an inserted id or takes its neighbour's entry on a pop. Depends on mqb_pkg.
module mqb_cell #(
  parameter int NUM_QUEUES = mqb_pkg::DEF_NUM_QUEUES,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                        clk,
  input  mqb_pkg::mqb_cell_ctrl_t     ctrl,
  input  logic [QW-1:0]               qsel,
  input  logic [mqb_pkg::ID_W-1:0]    ins_data,
  input  logic [mqb_pkg::ID_W-1:0]    shift_in,
  output logic [mqb_pkg::ID_W-1:0]    sel_out
);
  import mqb_pkg::*;

  logic [ID_W-1:0] slot [NUM_QUEUES];

  // Entry update for the selected queue only
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot[qsel] <= ins_data;
    end else if (ctrl.shift) begin
      slot[qsel] <= shift_in;
    end
  end

  // Selected queue's entry, towards the head-side neighbour
  assign sel_out = slot[qsel];

endmodule

// ===== rtl/multilevel_fifo_queue_bank_top.sv =====
// Top level of the multilevel queue bank: sequencer, entry counts, slot-cell
// chain and response register. Depends on mqb_pkg, mqb_req_if, mqb_rsp_if,
// mqb_reduce and mqb_cell.
//
// Usage
//   req: insert (cmd 0) or pop (cmd 1) against a signed queue number, which
//        is reduced to 0..NUM_QUEUES-1. One transfer when valid and ready.
//   rsp: one response per request: status, popped id, resolved queue and
//        the queue's count after the operation.
// Timing
//   Each request passes through the sequencer states: the accepting edge starts a
//   reciprocal multiply, the reduce step finishes the modulo reduction, and the
//   execute step applies the operation to the count and the cell chain and
//   registers the response. The response is valid once the execute step has
//   registered it; a new request is taken only when the sequencer is back in
//   idle, after the previous one has left the execute step.
// Reset
//   Synchronous rst empties all queues (counts cleared); slot contents are
//   left as they are, nothing reads them before they are written.
// Stall
//   A held response does not block acceptance or reduction of the next
//   request; that request waits in the execute step until rsp is taken.
module multilevel_fifo_queue_bank_top #(
  parameter int NUM_QUEUES  = mqb_pkg::DEF_NUM_QUEUES,
  parameter int QUEUE_DEPTH = mqb_pkg::DEF_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  mqb_req_if.sink    req,
  mqb_rsp_if.source  rsp
);
  import mqb_pkg::*;

  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  mqb_state_t       state, state_next;
  logic             req_xfer;
  logic             reduce_finish;
  logic             exec_go;

  logic [CMD_W-1:0] cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [QW-1:0]    qidx;

  logic [COUNT_W-1:0] count [NUM_QUEUES];
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic               is_pop;
  logic               pop_ok;
  logic               ins_ok;
  logic [STATUS_W-1:0] status_next;

  mqb_cell_ctrl_t   cell_ctrl [QUEUE_DEPTH];
  logic [ID_W-1:0]  cell_out  [QUEUE_DEPTH];

  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_popped;
  logic [RQ_W-1:0]     out_queue;
  logic [QC_W-1:0]     out_count;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_EXEC;
      ST_EXEC:   if (exec_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req.ready     = 1'b0;
    reduce_finish = 1'b0;
    exec_go       = 1'b0;
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_REDUCE: reduce_finish = 1'b1;
      ST_EXEC:   exec_go = !out_valid || rsp.ready;
      default:   req.ready = 1'b0;
    endcase
  end

  assign req_xfer = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request fields held for the execute step
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd_r <= req.cmd;
      id_r  <= req.proc_id;
    end
  end

  mqb_reduce #(.NUM_QUEUES(NUM_QUEUES)) u_reduce (
    .clk    (clk),
    .start  (req_xfer),
    .finish (reduce_finish),
    .sel    (req.queue_sel),
    .qidx   (qidx)
  );

  // Operation decode against the selected queue's count
  always_comb begin
    cnt    = count[qidx];
    is_pop = (cmd_r == CMD_POP);
    pop_ok = is_pop && (cnt != '0);
    ins_ok = !is_pop && (cnt != COUNT_W'(QUEUE_DEPTH));
    if (pop_ok) begin
      cnt_next = cnt - COUNT_W'(1);
    end else if (ins_ok) begin
      cnt_next = cnt + COUNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
    if (is_pop) begin
      status_next = pop_ok ? STATUS_OK : STATUS_EMPTY;
    end else begin
      status_next = ins_ok ? STATUS_OK : STATUS_FULL;
    end
  end

  // Entry counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        count[q] <= '0;
      end
    end else if (exec_go) begin
      count[qidx] <= cnt_next;
    end
  end

  // Slot cell chain: cell 0 is the head, each cell but the last takes from the next one
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] nbr;

    assign cell_ctrl[i].load  = exec_go && ins_ok && (cnt == COUNT_W'(i));
    assign cell_ctrl[i].shift = exec_go && pop_ok;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = cell_out[i];
    end else begin : g_mid
      assign nbr = cell_out[i + 1];
    end

    mqb_cell #(.NUM_QUEUES(NUM_QUEUES)) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .qsel     (qidx),
      .ins_data (id_r),
      .shift_in (nbr),
      .sel_out  (cell_out[i])
    );
  end

  // Response register
  always_comb begin
    if (exec_go) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status <= status_next;
      out_popped <= pop_ok ? cell_out[0] : '0;
      out_queue  <= RQ_W'(qidx);
      out_count  <= QC_W'(cnt_next);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.popped_id      = out_popped;
  assign rsp.resolved_queue = out_queue;
  assign rsp.queue_count    = out_count;

`ifndef NO_ASSERTIONS
  // An accepted request always moves on to the reduction step
  a_req_to_reduce: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state == ST_REDUCE)
    else $error("request transfer did not start reduction");

  // No request is taken while one is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req.ready)
    else $error("request ready while busy");

  // The selected count never exceeds the queue depth (queue index valid in execute)
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> cnt <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // A rejected operation leaves the count untouched
  a_reject_stable: assert property (@(posedge clk) disable iff (rst)
    exec_go && !pop_ok && !ins_ok |=> cnt == $past(cnt))
    else $error("count changed on full or empty status");

  // A successful insert grows the selected queue by one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    exec_go && ins_ok |=> cnt == $past(cnt) + COUNT_W'(1))
    else $error("count not incremented on insert");
`endif

endmodule
